FILE: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros for the crc32 framer
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define CTF_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// checked at every edge, reset included
`define CTF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

FILE: src/ctf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctf_pkg
// types, constants and the byte-wise crc-32 update for the trailer framer
// ----------------------------------------------------------------------------
package ctf_pkg;

  localparam int unsigned CRC_BYTES = 4;
  localparam int unsigned CRC_W     = 8 * CRC_BYTES;
  localparam int unsigned SEEN_W    = 3;
  localparam int unsigned TRL_W     = 3;
  localparam int unsigned PADDR_W   = 3;

  localparam logic [CRC_W-1:0] CRC_INIT = 32'hFFFF_FFFF;
  localparam logic [CRC_W-1:0] CRC_POLY = 32'hEDB8_8320;

  // word index of the mode register
  localparam logic REG_MODE = 1'b0;

  typedef enum logic {
    MODE_ENCODE = 1'b0,
    MODE_DECODE = 1'b1
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_SHORT    = 2'd1,
    ST_MISMATCH = 2'd2
  } status_e;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       frame_last;
    status_e    status;
  } result_t;

  // reflected crc-32, one byte
  function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] c,
                                                 input logic [7:0]       b);
    logic [CRC_W-1:0] r;
    r = c ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      r = (r >> 1) ^ (r[0] ? CRC_POLY : '0);
    end
    return r;
  endfunction

endpackage

FILE: src/ctf_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctf_datapath
// frame state, crc update, decode delay line and trailer sequencing
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ctf_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ctf_pkg::mode_e    mode_i,
  input  logic              clear_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [7:0]        in_data_i,
  input  logic              in_last_i,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output ctf_pkg::result_t  res_o
);

  logic [ctf_pkg::CRC_W-1:0]  crc_q, crc_d;
  logic [ctf_pkg::CRC_W-1:0]  fcs_q, fcs_d;
  logic [ctf_pkg::SEEN_W-1:0] seen_q, seen_d;
  logic [ctf_pkg::TRL_W-1:0]  trl_cnt_q, trl_cnt_d;
  logic [7:0]                 tail_q [ctf_pkg::CRC_BYTES];
  logic [7:0]                 tail_d [ctf_pkg::CRC_BYTES];

  logic                      accept;
  logic                      trl_emit;
  logic                      line_full;
  logic [7:0]                pay_byte;
  logic [7:0]                crc_in;
  logic [ctf_pkg::CRC_W-1:0] crc_upd;
  logic [ctf_pkg::CRC_W-1:0] held;

  assign in_ready_o = res_ready_i && (trl_cnt_q == '0);
  assign accept     = in_valid_i && in_ready_o;
  assign trl_emit   = res_ready_i && (trl_cnt_q != '0);
  assign line_full  = seen_q[2];
  assign pay_byte   = tail_q[0];

  // encode hashes the incoming byte, decode the one leaving the delay line
  assign crc_in  = (mode_i == ctf_pkg::MODE_ENCODE) ? in_data_i : pay_byte;
  assign crc_upd = ctf_pkg::crc_byte(crc_q, crc_in);
  // delay line contents after the shift, read little endian
  assign held    = {in_data_i, tail_q[3], tail_q[2], tail_q[1]};

  always_comb begin
    crc_d       = crc_q;
    fcs_d       = fcs_q;
    seen_d      = seen_q;
    trl_cnt_d   = trl_cnt_q;
    tail_d      = tail_q;
    res_valid_o = 1'b0;
    res_o       = '{out_byte: 8'd0, byte_valid: 1'b0, frame_last: 1'b0,
                    status: ctf_pkg::ST_OK};

    if (trl_emit) begin
      res_valid_o      = 1'b1;
      res_o.out_byte   = fcs_q[7:0];
      res_o.byte_valid = 1'b1;
      res_o.frame_last = (trl_cnt_q == ctf_pkg::TRL_W'(1));
      fcs_d            = fcs_q >> 8;
      trl_cnt_d        = trl_cnt_q - ctf_pkg::TRL_W'(1);
    end else if (accept) begin
      if (mode_i == ctf_pkg::MODE_ENCODE) begin
        res_valid_o      = 1'b1;
        res_o.out_byte   = in_data_i;
        res_o.byte_valid = 1'b1;
        crc_d            = crc_upd;
        if (in_last_i) begin
          fcs_d     = ~crc_upd;
          trl_cnt_d = ctf_pkg::TRL_W'(ctf_pkg::CRC_BYTES);
          crc_d     = ctf_pkg::CRC_INIT;
        end
      end else if (line_full) begin
        res_valid_o      = 1'b1;
        res_o.out_byte   = pay_byte;
        res_o.byte_valid = 1'b1;
        crc_d            = crc_upd;
        for (int i = 0; i < ctf_pkg::CRC_BYTES - 1; i++) begin
          tail_d[i] = tail_q[i+1];
        end
        tail_d[ctf_pkg::CRC_BYTES-1] = in_data_i;
        if (in_last_i) begin
          res_o.frame_last = 1'b1;
          res_o.status     = (held == ~crc_upd) ? ctf_pkg::ST_OK : ctf_pkg::ST_MISMATCH;
          crc_d            = ctf_pkg::CRC_INIT;
          seen_d           = '0;
        end
      end else begin
        tail_d[seen_q[1:0]] = in_data_i;
        seen_d              = seen_q + ctf_pkg::SEEN_W'(1);
        if (in_last_i) begin
          // four bytes or fewer: no payload at all
          res_valid_o      = 1'b1;
          res_o.frame_last = 1'b1;
          res_o.status     = ctf_pkg::ST_SHORT;
          crc_d            = ctf_pkg::CRC_INIT;
          seen_d           = '0;
        end
      end
    end

    if (clear_i) begin
      crc_d  = ctf_pkg::CRC_INIT;
      seen_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q     <= ctf_pkg::CRC_INIT;
      seen_q    <= '0;
      trl_cnt_q <= '0;
    end else begin
      crc_q     <= crc_d;
      seen_q    <= seen_d;
      trl_cnt_q <= trl_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fcs_q  <= fcs_d;
    tail_q <= tail_d;
  end

  `CTF_ASSERT(a_trailer_blocks_input, clk_i, rst_ni,
    (trl_cnt_q != '0) |-> !in_ready_o, "input taken during trailer")
  `CTF_ASSERT(a_encode_end_loads_trailer, clk_i, rst_ni,
    (accept && (mode_i == ctf_pkg::MODE_ENCODE) && in_last_i)
      |=> (trl_cnt_q == ctf_pkg::TRL_W'(ctf_pkg::CRC_BYTES)),
    "trailer not started after encode frame end")
  `CTF_ASSERT_ALWAYS(a_seen_bounded, clk_i,
    seen_q <= ctf_pkg::SEEN_W'(ctf_pkg::CRC_BYTES), "delay line count overflow")

endmodule

FILE: src/ctf_out_buf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctf_out_buf
// two-entry output register with skid slot, registered ready toward the core
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ctf_out_buf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  ctf_pkg::result_t  in_res_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output ctf_pkg::result_t  out_res_o
);

  logic             head_v_q, head_v_d;
  logic             skid_v_q, skid_v_d;
  ctf_pkg::result_t head_q, head_d;
  ctf_pkg::result_t skid_q, skid_d;
  logic             push;
  logic             pop;

  assign in_ready_o  = !skid_v_q;
  assign out_valid_o = head_v_q;
  assign out_res_o   = head_q;
  assign push        = in_valid_i && in_ready_o;
  assign pop         = head_v_q && out_ready_i;

  always_comb begin
    head_v_d = head_v_q;
    skid_v_d = skid_v_q;
    head_d   = head_q;
    skid_d   = skid_q;
    if (!head_v_q || pop) begin
      if (skid_v_q) begin
        head_d   = skid_q;
        head_v_d = 1'b1;
        skid_v_d = 1'b0;
      end else begin
        head_d   = in_res_i;
        head_v_d = push;
      end
    end else if (push) begin
      skid_d   = in_res_i;
      skid_v_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_v_q <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      head_v_q <= head_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_q <= head_d;
    skid_q <= skid_d;
  end

  `CTF_ASSERT_ALWAYS(a_skid_needs_head, clk_i,
    skid_v_q |-> head_v_q, "skid slot filled with empty head")
  `CTF_ASSERT(a_stall_fills_skid, clk_i, rst_ni,
    (head_v_q && !out_ready_i && push) |=> skid_v_q, "beat lost on stalled output")

endmodule

FILE: src/crc32_trailer_framer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc32_trailer_framer_core
// crc-32 frame check sequence framer: append in encode, check and strip in decode
// ----------------------------------------------------------------------------
// Takes one byte beat per cycle on the slave stream while neither a trailer nor
// a full output buffer holds it off. In encode mode each byte leaves through
// the output register; the last byte of a frame is followed by the four crc
// bytes, least significant first, during which the input is held off. In
// decode mode bytes pass through a four-byte delay line with no trailer
// hold-off; the beat that ends the frame carries the status in tuser (ok, too
// short or mismatch), and a frame of four bytes or fewer gives a single
// status-only beat. The byte-wise crc update is one combinational step, which
// is what sets the one-byte-per-cycle figure. A write to the mode register
// drops any frame in progress; write it only while the block is idle.
// ----------------------------------------------------------------------------

module crc32_trailer_framer_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ctf_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  // input stream
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [7:0]                  s_axis_tdata,  // [7:0] data_byte
  input  logic                        s_axis_tlast,  // frame_end
  // output stream
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [7:0]                  m_axis_tdata,  // [7:0] out_byte
  output logic                        m_axis_tlast,  // frame_last
  output logic [2:0]                  m_axis_tuser   // [0] byte_valid, [2:1] status
);

  ctf_pkg::mode_e   mode_q, mode_d;
  logic             mode_wr;
  logic             res_valid;
  logic             res_ready;
  ctf_pkg::result_t res;
  ctf_pkg::result_t out_res;

  assign pready  = 1'b1;
  assign mode_wr = psel && penable && pwrite && pready && (paddr[2] == ctf_pkg::REG_MODE);
  assign mode_d  = mode_wr ? ctf_pkg::mode_e'(pwdata[0]) : mode_q;
  assign prdata  = {31'd0, mode_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ctf_pkg::MODE_ENCODE;
    end else begin
      mode_q <= mode_d;
    end
  end

  ctf_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mode_i      (mode_q),
    .clear_i     (mode_wr),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_data_i   (s_axis_tdata),
    .in_last_i   (s_axis_tlast),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  ctf_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (res_valid),
    .in_ready_o  (res_ready),
    .in_res_i    (res),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_res_o   (out_res)
  );

  assign m_axis_tdata = out_res.out_byte;
  assign m_axis_tlast = out_res.frame_last;
  assign m_axis_tuser = {out_res.status, out_res.byte_valid};

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// stream-level check of the crc-32 trailer framer in encode and decode mode
// ----------------------------------------------------------------------------
// Byte beats go in on the slave stream with random gaps while the master side
// stalls at random. A scoreboard predicts every output beat from the accepted
// input beats and the current mode, and compares each beat in order. Decode
// phases mostly carry frames with a correct trailer, plus corrupted, short and
// abandoned frames. The mode register is rewritten between phases and read
// back; one phase holds the output off long enough to back up the input.
// ----------------------------------------------------------------------------

module testbench;

  localparam int unsigned LIMIT     = 500000;
  localparam int unsigned DRAIN     = 16;
  localparam int unsigned LONG_HOLD = 400;
  localparam int unsigned ITEMS     = 430;
  localparam logic [ctf_pkg::PADDR_W-1:0] MODE_ADDR =
    ctf_pkg::PADDR_W'(4 * ctf_pkg::REG_MODE);

  typedef enum {FRM_GOOD, FRM_BAD, FRM_RAW} frame_kind_e;

  class framer_scoreboard;
    logic [31:0]      crc_reg;
    logic [7:0]       delay_line[4];
    int unsigned      held_cnt;
    ctf_pkg::mode_e   mode;
    ctf_pkg::result_t expected_beats[$];
    int               errors;

    function new();
      mode   = ctf_pkg::MODE_ENCODE;
      errors = 0;
      clear();
    endfunction

    static function logic [31:0] crc_step(logic [31:0] c, logic [7:0] b);
      for (int k = 0; k < 8; k++) begin
        c = (c >> 1) ^ ((c[0] ^ b[k]) ? 32'hEDB8_8320 : 32'd0);
      end
      return c;
    endfunction

    function void clear();
      crc_reg  = 32'hFFFF_FFFF;
      held_cnt = 0;
      foreach (delay_line[i]) delay_line[i] = 8'd0;
    endfunction

    function void set_mode(ctf_pkg::mode_e m);
      mode = m;
      clear();
    endfunction

    function void push(logic [7:0] b, logic v, logic l, ctf_pkg::status_e s);
      ctf_pkg::result_t r;
      r.out_byte   = b;
      r.byte_valid = v;
      r.frame_last = l;
      r.status     = s;
      expected_beats.push_back(r);
    endfunction

    function void take_byte(logic [7:0] b, logic fin);
      logic [31:0] fcs;
      logic [31:0] held;
      logic [7:0]  pay;
      if (mode == ctf_pkg::MODE_ENCODE) begin
        push(b, 1'b1, 1'b0, ctf_pkg::ST_OK);
        crc_reg = crc_step(crc_reg, b);
        if (fin) begin
          fcs = ~crc_reg;
          for (int i = 0; i < 4; i++) push(fcs[8*i +: 8], 1'b1, i == 3, ctf_pkg::ST_OK);
          clear();
        end
      end else if (held_cnt >= 4) begin
        pay     = delay_line[0];
        crc_reg = crc_step(crc_reg, pay);
        for (int i = 0; i < 3; i++) delay_line[i] = delay_line[i+1];
        delay_line[3] = b;
        if (fin) begin
          held = {delay_line[3], delay_line[2], delay_line[1], delay_line[0]};
          push(pay, 1'b1, 1'b1,
               (held == ~crc_reg) ? ctf_pkg::ST_OK : ctf_pkg::ST_MISMATCH);
          clear();
        end else begin
          push(pay, 1'b1, 1'b0, ctf_pkg::ST_OK);
        end
      end else begin
        delay_line[held_cnt] = b;
        held_cnt++;
        if (fin) begin
          push(8'd0, 1'b0, 1'b1, ctf_pkg::ST_SHORT);
          clear();
        end
      end
    endfunction

    task report(string what);
      $display("mismatch: %s", what);
      errors++;
    endtask

    task check_beat(logic [7:0] d, logic l, logic [2:0] u);
      ctf_pkg::result_t e;
      if (expected_beats.size() == 0) begin
        report($sformatf("beat with nothing expected (byte %02h last %b user %b)", d, l, u));
        return;
      end
      e = expected_beats.pop_front();
      if (d !== e.out_byte)
        report($sformatf("out_byte %02h, want %02h", d, e.out_byte));
      if (u[0] !== e.byte_valid)
        report($sformatf("byte_valid %b, want %b", u[0], e.byte_valid));
      if (l !== e.frame_last)
        report($sformatf("frame_last %b, want %b", l, e.frame_last));
      if (u[2:1] !== e.status)
        report($sformatf("status %0d, want %0d", u[2:1], e.status));
    endtask

    function int pending();
      return expected_beats.size();
    endfunction
  endclass

  logic                        clk_i;
  logic                        rst_ni;
  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [ctf_pkg::PADDR_W-1:0] paddr;
  logic [31:0]                 pwdata;
  logic [31:0]                 prdata;
  logic                        pready;
  logic                        s_axis_tvalid;
  logic                        s_axis_tready;
  logic [7:0]                  s_axis_tdata;   // [7:0] data_byte
  logic                        s_axis_tlast;   // frame_end
  logic                        m_axis_tvalid;
  logic                        m_axis_tready;
  logic [7:0]                  m_axis_tdata;   // [7:0] out_byte
  logic                        m_axis_tlast;   // frame_last
  logic [2:0]                  m_axis_tuser;   // [0] byte_valid, [2:1] status

  crc32_trailer_framer_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  framer_scoreboard board = new();
  ctf_pkg::mode_e cur_mode = ctf_pkg::MODE_ENCODE;
  int unsigned items_sent = 0;
  int unsigned idle_pct = 0;
  bit          quiet = 1'b0;
  int unsigned hold_requests = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  int unsigned cycles = 0;

  initial begin
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    m_axis_tready = 1'b0;
  end

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  // input beat first, so a same-edge output could already be predicted
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) board.take_byte(s_axis_tdata, s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready)
        board.check_beat(m_axis_tdata, m_axis_tlast, m_axis_tuser);
    end
  end

  // output side: random stall bursts and the occasional long hold-off
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_requests != hold_seen) begin
        hold_seen     = hold_requests;
        hold_left     = LONG_HOLD;
        m_axis_tready = 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        m_axis_tready = 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        hold_left     = $urandom_range(1, 19) - 1;
        m_axis_tready = 1'b0;
      end else begin
        m_axis_tready = 1'b1;
      end
    end
  end

  // entered and left at a falling edge
  task automatic send_byte(logic [7:0] b, logic fin);
    if (!quiet && idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = b;
    s_axis_tlast  = fin;
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_frame(int unsigned len, frame_kind_e kind, int fill, bit closed);
    logic [7:0]  frame_q[$];
    logic [7:0]  b;
    logic [31:0] c;
    int unsigned pos;
    c = 32'hFFFF_FFFF;
    for (int i = 0; i < len; i++) begin
      b = (fill < 0) ? 8'($urandom) : fill[7:0];
      frame_q.push_back(b);
      c = framer_scoreboard::crc_step(c, b);
    end
    if (cur_mode == ctf_pkg::MODE_DECODE && kind != FRM_RAW) begin
      c = ~c;
      for (int k = 0; k < 4; k++) frame_q.push_back(c[8*k +: 8]);
      if (kind == FRM_BAD) begin
        pos = $urandom_range(0, frame_q.size() - 1);
        frame_q[pos] = frame_q[pos] ^ (8'h01 << $urandom_range(0, 7));
      end
    end
    foreach (frame_q[i]) send_byte(frame_q[i], closed && (i == frame_q.size() - 1));
  endtask

  // wait for the last expected beat, then let any held bytes settle
  task automatic settle();
    s_axis_tvalid = 1'b0;
    s_axis_tlast  = 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_mode(ctf_pkg::mode_e m);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = MODE_ADDR;
    pwdata  = {31'd0, m};
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    board.set_mode(m);
    cur_mode = m;
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic read_mode();
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = MODE_ADDR;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== {31'd0, board.mode})
      board.report($sformatf("mode reads %08h, want %0d", prdata, board.mode));
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  task automatic run_phase(ctf_pkg::mode_e m, int unsigned frames, bit squeeze);
    int unsigned len;
    int unsigned pick;
    frame_kind_e kind;
    settle();
    write_mode(m);
    read_mode();
    if (squeeze) hold_requests++;
    for (int f = 0; f < frames; f++) begin
      len  = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 8);
      pick = $urandom_range(0, 99);
      kind = (pick < 70) ? FRM_GOOD : (pick < 85) ? FRM_BAD : FRM_RAW;
      if (kind == FRM_RAW && m == ctf_pkg::MODE_DECODE) len = $urandom_range(1, 4);
      send_frame(len, kind, -1, 1'b1);
    end
    // abandoned frame, dropped by the next mode write
    if (!quiet && $urandom_range(0, 3) == 0)
      send_frame($urandom_range(1, 9), FRM_RAW, -1, 1'b0);
  endtask

  initial begin
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // encode from reset: byte extremes and a two-byte frame
    read_mode();
    idle_pct = 30;
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h5A, 1'b0);
    send_byte(8'hA5, 1'b1);

    // decode: too short at one and four bytes, minimal good and bad frames
    settle();
    write_mode(ctf_pkg::MODE_DECODE);
    read_mode();
    send_frame(1, FRM_RAW, 8'hFF, 1'b1);
    send_frame(4, FRM_RAW, 8'h00, 1'b1);
    send_frame(1, FRM_GOOD, 8'hFF, 1'b1);
    send_frame(1, FRM_BAD, 8'h00, 1'b1);
    send_frame(2, FRM_GOOD, -1, 1'b1);

    // encode with the output held off for a long stretch
    idle_pct = 0;
    run_phase(ctf_pkg::MODE_ENCODE, 6, 1'b1);

    // the last random phase overshoots and the closing phases add about seventy
    while (items_sent < ITEMS - 100) begin
      case ($urandom_range(0, 2))
        0: idle_pct = 0;
        1: idle_pct = 10;
        default: idle_pct = 50;
      endcase
      run_phase(($urandom_range(0, 2) == 0) ? ctf_pkg::MODE_ENCODE : ctf_pkg::MODE_DECODE,
                $urandom_range(3, 8), 1'b0);
    end

    quiet = 1'b1;
    run_phase(ctf_pkg::MODE_DECODE, 5, 1'b0);
    run_phase(ctf_pkg::MODE_ENCODE, 3, 1'b0);
    settle();

    if (board.errors == 0 && board.pending() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
